// File: sv/bph_pkg.sv
// Shared types, constants and command structs for the board position hash block.
package bph_pkg;

	// Key generator constants
	localparam logic [63:0] KEY_SEED  = 64'hC1A0D00D5EED1234;
	localparam logic [63:0] KEY_GAMMA = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] KEY_MUL1  = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] KEY_MUL2  = 64'h94D049BB133111EB;

	localparam int unsigned MIX_SHIFT1 = 30;
	localparam int unsigned MIX_SHIFT2 = 27;
	localparam int unsigned MIX_SHIFT3 = 31;

	// Board geometry and key table layout
	localparam int unsigned SQUARES         = 64;
	localparam int unsigned PIECE_KINDS_DEF = 12;
	localparam int unsigned CASTLE_KEYS     = 16;
	localparam int unsigned EP_KEYS         = 8;

	// Key jobs per item, in the order they are run
	localparam int unsigned KEY_COUNT = 5;

	typedef enum logic [2:0] {
		KEY_PIECE  = 3'd0,
		KEY_PAWN   = 3'd1,
		KEY_CASTLE = 3'd2,
		KEY_EP     = 3'd3,
		KEY_SIDE   = 3'd4
	} key_sel_t;

	// Datapath operation for the current cycle
	typedef enum logic [2:0] {
		MIX_NONE,
		MIX_BASE,
		MIX_P0,
		MIX_P1,
		MIX_P2,
		MIX_ACC
	} mix_op_t;

	typedef struct packed {
		logic [5:0] square;
		logic       occupied;
		logic [3:0] piece_kind;
		logic       pawn_here;
		logic       pawn_black;
		logic       last;
		logic [3:0] castle_rights;
		logic       ep_valid;
		logic [2:0] ep_file;
		logic       black_to_move;
	} item_t;

	typedef struct packed {
		logic [63:0] position_hash;
		logic [63:0] pawn_hash;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic     capture;
		mix_op_t  op;
		logic     round;
		key_sel_t key;
		logic     emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [KEY_COUNT-1:0] need;
		logic                 last;
	} status_t;

endpackage

// File: sv/board_position_hash.sv
// Top level of the board position hash block: controller plus datapath.
//
// Zobrist hash of a chess position, one square per input transaction, with
// splitmix64 keys generated on demand. Each key is built by one shared
// 32x32 multiplier: the counter value is loaded, three partial products are
// formed per mixing round over two rounds, and the key is then folded in. An
// item is finished before the next is accepted: it runs k key jobs, where k
// is 0 to 2 on ordinary squares (piece key when occupied and the piece kind
// is in range, pawn key when occupied with a pawn), plus 1 to 3 on the last
// square (castling always, en passant and side when flagged), and the last
// square also loads the result register. The result waits in its own
// register, so new squares are accepted while it is not yet taken; only a
// following last square stalls until the previous result is gone.
module board_position_hash #(
	parameter int unsigned PIECE_KINDS = bph_pkg::PIECE_KINDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  bph_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_ready,
	output bph_pkg::result_t  result
);

	bph_pkg::cmd_t     cmd;
	bph_pkg::status_t  status;

	bph_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	bph_datapath #(
		.PIECE_KINDS (PIECE_KINDS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

// File: sv/bph_datapath.sv
// Datapath: item register, splitmix64 key mixer on a shared 32x32 multiplier, accumulators.
module bph_datapath #(
	parameter int unsigned PIECE_KINDS = bph_pkg::PIECE_KINDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bph_pkg::item_t    item,
	input  bph_pkg::cmd_t     cmd,
	output bph_pkg::status_t  status,
	output bph_pkg::result_t  result
);

	localparam int unsigned KEY_TOTAL = PIECE_KINDS * bph_pkg::SQUARES
		+ 2 * bph_pkg::SQUARES + bph_pkg::CASTLE_KEYS + bph_pkg::EP_KEYS + 1;
	localparam int unsigned IDX_W = $clog2(KEY_TOTAL);
	localparam logic [IDX_W-1:0] PAWN_BASE   = IDX_W'(PIECE_KINDS * bph_pkg::SQUARES);
	localparam logic [IDX_W-1:0] CASTLE_BASE =
		IDX_W'(PIECE_KINDS * bph_pkg::SQUARES + 2 * bph_pkg::SQUARES);
	localparam logic [IDX_W-1:0] EP_BASE     =
		IDX_W'(PIECE_KINDS * bph_pkg::SQUARES + 2 * bph_pkg::SQUARES + bph_pkg::CASTLE_KEYS);
	localparam logic [IDX_W-1:0] SIDE_INDEX  = IDX_W'(KEY_TOTAL - 1);

	bph_pkg::item_t    item_q;
	logic [63:0]       z_q;
	logic [63:0]       prod_q;
	logic [63:0]       full_acc_q;
	logic [63:0]       pawn_acc_q;
	bph_pkg::result_t  result_q;

	logic [IDX_W-1:0]  key_idx;
	logic [IDX_W:0]    idx_plus1;
	logic [63:0]       base_val;
	logic [63:0]       mix_x;
	logic [63:0]       mix_m;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       mul_p;
	logic [63:0]       key_val;

	// Capture the item while the controller works on it
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	// Key jobs this item needs
	always_comb begin
		status.need = '0;
		status.need[bph_pkg::KEY_PIECE] = item_q.occupied
			&& ({1'b0, item_q.piece_kind} < 5'(PIECE_KINDS));
		status.need[bph_pkg::KEY_PAWN]   = item_q.occupied && item_q.pawn_here;
		status.need[bph_pkg::KEY_CASTLE] = item_q.last;
		status.need[bph_pkg::KEY_EP]     = item_q.last && item_q.ep_valid;
		status.need[bph_pkg::KEY_SIDE]   = item_q.last && item_q.black_to_move;
		status.last = item_q.last;
	end

	// Select the key index of the current job
	always_comb begin
		case (cmd.key)
			bph_pkg::KEY_PIECE:  key_idx = IDX_W'({item_q.piece_kind, item_q.square});
			bph_pkg::KEY_PAWN:   key_idx = PAWN_BASE + IDX_W'({item_q.pawn_black, item_q.square});
			bph_pkg::KEY_CASTLE: key_idx = CASTLE_BASE + IDX_W'(item_q.castle_rights);
			bph_pkg::KEY_EP:     key_idx = EP_BASE + IDX_W'(item_q.ep_file);
			bph_pkg::KEY_SIDE:   key_idx = SIDE_INDEX;
			default:             key_idx = '0;
		endcase
	end

	// Counter value seed + (n+1)*gamma; the index is narrow, so this is a small constant multiply
	assign idx_plus1 = {1'b0, key_idx} + (IDX_W+1)'(1);
	assign base_val  = bph_pkg::KEY_SEED + 64'(idx_plus1) * bph_pkg::KEY_GAMMA;

	// Mixer operand and constant for the current round
	assign mix_x = cmd.round ? (z_q ^ (z_q >> bph_pkg::MIX_SHIFT2))
	                         : (z_q ^ (z_q >> bph_pkg::MIX_SHIFT1));
	assign mix_m = cmd.round ? bph_pkg::KEY_MUL2 : bph_pkg::KEY_MUL1;

	// Shared 32x32 multiplier: low*low, high*low, low*high partial products
	always_comb begin
		case (cmd.op)
			bph_pkg::MIX_P1: begin
				mul_a = mix_x[63:32];
				mul_b = mix_m[31:0];
			end
			bph_pkg::MIX_P2: begin
				mul_a = mix_x[31:0];
				mul_b = mix_m[63:32];
			end
			default: begin
				mul_a = mix_x[31:0];
				mul_b = mix_m[31:0];
			end
		endcase
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	assign key_val = z_q ^ (z_q >> bph_pkg::MIX_SHIFT3);

	// Advance the mixer: load the counter value, then build each product mod 2^64
	always_ff @(posedge clk) begin
		case (cmd.op)
			bph_pkg::MIX_BASE: z_q <= base_val;
			bph_pkg::MIX_P0:   prod_q <= mul_p;
			bph_pkg::MIX_P1:   prod_q[63:32] <= prod_q[63:32] + mul_p[31:0];
			bph_pkg::MIX_P2:   z_q <= {prod_q[63:32] + mul_p[31:0], prod_q[31:0]};
			default: begin
			end
		endcase
	end

	// Fold finished keys into the accumulators; clear them when the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_acc_q <= '0;
			pawn_acc_q <= '0;
		end else if (cmd.emit) begin
			full_acc_q <= '0;
			pawn_acc_q <= '0;
		end else if (cmd.op == bph_pkg::MIX_ACC) begin
			if (cmd.key == bph_pkg::KEY_PAWN) begin
				pawn_acc_q <= pawn_acc_q ^ key_val;
			end else begin
				full_acc_q <= full_acc_q ^ key_val;
			end
		end
	end

	// Hold the result until the controller loads the next one
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.position_hash <= full_acc_q;
			result_q.pawn_hash     <= pawn_acc_q;
		end
	end

	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (full_acc_q == '0) && (pawn_acc_q == '0))
		else $error("accumulators not cleared after result load");
`endif

endmodule

// File: sv/bph_ctrl.sv
// Controller: sequences key jobs per item through the mixer and loads the result register.
module bph_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	output logic              result_valid,
	input  logic              result_ready,
	input  bph_pkg::status_t  status,
	output bph_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_BASE,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_ACC,
		ST_EMIT
	} state_t;

	state_t             state_q;
	bph_pkg::key_sel_t  key_q;
	logic               round_q;
	logic               result_valid_q;

	logic [3:0]         pick_first;
	logic [3:0]         pick_next;
	logic               emit_go;

	// Lowest needed key job at or after start; top bit flags a hit
	function automatic logic [3:0] pick_key(input logic [bph_pkg::KEY_COUNT-1:0] need,
	                                        input logic [3:0] start);
		logic [3:0] r;
		r = '0;
		for (int j = bph_pkg::KEY_COUNT - 1; j >= 0; j--) begin
			if (need[j] && (4'(j) >= start)) begin
				r = {1'b1, 3'(j)};
			end
		end
		return r;
	endfunction

	assign pick_first = pick_key(status.need, 4'd0);
	assign pick_next  = pick_key(status.need, {1'b0, key_q} + 4'd1);
	assign emit_go    = (state_q == ST_EMIT) && (!result_valid_q || result_ready);

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;

	// Hold state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			key_q          <= bph_pkg::KEY_PIECE;
			round_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pick_first[3]) begin
						key_q   <= bph_pkg::key_sel_t'(pick_first[2:0]);
						round_q <= 1'b0;
						state_q <= ST_BASE;
					end else begin
						state_q <= status.last ? ST_EMIT : ST_IDLE;
					end
				end
				ST_BASE: state_q <= ST_P0;
				ST_P0:   state_q <= ST_P1;
				ST_P1:   state_q <= ST_P2;
				ST_P2: begin
					if (!round_q) begin
						round_q <= 1'b1;
						state_q <= ST_P0;
					end else begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (pick_next[3]) begin
						key_q   <= bph_pkg::key_sel_t'(pick_next[2:0]);
						round_q <= 1'b0;
						state_q <= ST_BASE;
					end else begin
						state_q <= status.last ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Decode datapath commands from state
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && item_valid;
		cmd.round   = round_q;
		cmd.key     = key_q;
		cmd.emit    = emit_go;
		case (state_q)
			ST_BASE: cmd.op = bph_pkg::MIX_BASE;
			ST_P0:   cmd.op = bph_pkg::MIX_P0;
			ST_P1:   cmd.op = bph_pkg::MIX_P1;
			ST_P2:   cmd.op = bph_pkg::MIX_P2;
			ST_ACC:  cmd.op = bph_pkg::MIX_ACC;
			default: cmd.op = bph_pkg::MIX_NONE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_accept_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q == ST_SCAN))
		else $error("accepted transaction did not start a scan");

	a_acc_after_two_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (($past(state_q) == ST_P2) && $past(round_q)))
		else $error("key folded before both mixer rounds");

	a_emit_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.last)
		else $error("result loaded for a transaction without last");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for board_position_hash: streamed squares, predicted Zobrist hashes.
module tb;

	localparam int unsigned KIND_COUNT = 12;
	localparam int unsigned ITEM_W = $bits(bph_pkg::item_t);

	// splitmix64 key generator constants
	localparam logic [63:0] SEED  = 64'hC1A0D00D5EED1234;
	localparam logic [63:0] GAMMA = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MUL1  = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MUL2  = 64'h94D049BB133111EB;

	// Key table layout: piece keys, white and black pawn keys, castling, en passant, side
	localparam logic [63:0] PAWN_BASE   = 64'(KIND_COUNT * 64);
	localparam logic [63:0] CASTLE_BASE = PAWN_BASE + 64'd128;
	localparam logic [63:0] EP_BASE     = CASTLE_BASE + 64'd16;
	localparam logic [63:0] SIDE_KEY    = EP_BASE + 64'd8;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	bph_pkg::item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	bph_pkg::result_t result;

	bph_pkg::item_t   pending_squares [$];
	bph_pkg::result_t expected_hashes [$];
	logic [63:0] board_acc = '0;
	logic [63:0] pawn_acc = '0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned mismatch_count = 0;

	board_position_hash #(
		.PIECE_KINDS(KIND_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #10 clk = ~clk;

	// Derive one Zobrist key from the splitmix64 counter
	function automatic logic [63:0] zobrist_key(input logic [63:0] index);
		logic [63:0] z;
		z = SEED + (index + 64'd1) * GAMMA;
		z = (z ^ (z >> 30)) * MUL1;
		z = (z ^ (z >> 27)) * MUL2;
		return z ^ (z >> 31);
	endfunction

	// Fold one accepted square into the running hashes; close the position on last
	task automatic hash_square(input bph_pkg::item_t sq);
		bph_pkg::result_t closed;
		if (sq.occupied) begin
			if (sq.piece_kind < KIND_COUNT)
				board_acc ^= zobrist_key({54'd0, sq.piece_kind, sq.square});
			if (sq.pawn_here)
				pawn_acc ^= zobrist_key(PAWN_BASE + {57'd0, sq.pawn_black, sq.square});
		end
		if (sq.last) begin
			closed.position_hash = board_acc ^ zobrist_key(CASTLE_BASE + 64'(sq.castle_rights));
			if (sq.ep_valid)
				closed.position_hash ^= zobrist_key(EP_BASE + 64'(sq.ep_file));
			if (sq.black_to_move)
				closed.position_hash ^= zobrist_key(SIDE_KEY);
			closed.pawn_hash = pawn_acc;
			expected_hashes.push_back(closed);
			board_acc = '0;
			pawn_acc = '0;
		end
	endtask

	function automatic bph_pkg::item_t board_square(int sq, bit occ, int kind, bit pawn,
	                                                bit black);
		bph_pkg::item_t it;
		it = '0;
		it.square = 6'(sq);
		it.occupied = occ;
		it.piece_kind = 4'(kind);
		it.pawn_here = pawn;
		it.pawn_black = black;
		return it;
	endfunction

	function automatic bph_pkg::item_t closing(bph_pkg::item_t base, int rights, bit ep,
	                                           int file, bit btm);
		bph_pkg::item_t it;
		it = base;
		it.last = 1'b1;
		it.castle_rights = 4'(rights);
		it.ep_valid = ep;
		it.ep_file = 3'(file);
		it.black_to_move = btm;
		return it;
	endfunction

	// Queue random positions: mostly well-formed boards, some raw noise
	task automatic queue_positions(input int budget);
		int queued;
		int len;
		int sq;
		int kind;
		int burst;
		bit taken [64];
		bph_pkg::item_t it;
		queued = 0;
		while (queued < budget) begin
			if ($urandom_range(99) < 85) begin
				foreach (taken[i])
					taken[i] = 1'b0;
				len = $urandom_range(15);
				for (int i = 0; i <= len; i++) begin
					do
						sq = $urandom_range(63);
					while (taken[sq]);
					taken[sq] = 1'b1;
					kind = $urandom_range(KIND_COUNT - 1);
					it = board_square(sq, $urandom_range(99) < 75, kind,
						kind == 0 || kind == 6, kind >= 6);
					if (i == len)
						it = closing(it, $urandom_range(15), 1'($urandom_range(1)),
							$urandom_range(7), 1'($urandom_range(1)));
					pending_squares.push_back(it);
					queued++;
				end
			end else begin
				burst = $urandom_range(1, 6);
				repeat (burst) begin
					it = bph_pkg::item_t'(ITEM_W'($urandom()));
					it.last = ($urandom_range(7) == 0);
					pending_squares.push_back(it);
					queued++;
				end
			end
		end
	endtask

	// Wait until every queued square is taken and every hash has come back
	task automatic drain_all();
		do
			@(negedge clk);
		while (pending_squares.size() != 0 || item_valid || expected_hashes.size() != 0);
	endtask

	// Drive squares; hold valid and payload until the transaction completes
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (pending_squares.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item_valid <= 1'b1;
				item <= pending_squares.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		result_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Check completed results first, then predict from the accepted square
	always @(posedge clk) begin : monitor
		bph_pkg::result_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_hashes.size() == 0) begin
					$display("%0t: unexpected result position_hash %h pawn_hash %h",
						$time, result.position_hash, result.pawn_hash);
					mismatch_count++;
				end else begin
					want = expected_hashes.pop_front();
					if (result.position_hash !== want.position_hash) begin
						$display("%0t: position_hash expected %h actual %h",
							$time, want.position_hash, result.position_hash);
						mismatch_count++;
					end
					if (result.pawn_hash !== want.pawn_hash) begin
						$display("%0t: pawn_hash expected %h actual %h",
							$time, want.pawn_hash, result.pawn_hash);
						mismatch_count++;
					end
				end
			end
			if (item_valid && item_ready)
				hash_square(item);
		end
	end

	// Stimulus and verdict
	initial begin
		bph_pkg::item_t it;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 11;
		recv_idle_pct = 87;

		// Extremes of square and kind, pawn colors, out-of-range kinds,
		// pawn flag on empty square, final fields ignored before last
		it = board_square(0, 1, 0, 1, 0);
		it.castle_rights = 4'hF;
		it.ep_valid = 1'b1;
		it.ep_file = 3'd7;
		it.black_to_move = 1'b1;
		pending_squares.push_back(it);
		pending_squares.push_back(board_square(63, 1, 11, 1, 1));
		pending_squares.push_back(board_square(5, 1, 12, 1, 1));
		pending_squares.push_back(board_square(6, 1, 15, 0, 0));
		pending_squares.push_back(board_square(7, 0, 3, 1, 1));
		pending_squares.push_back(closing(board_square(42, 1, 4, 0, 0), 15, 1, 7, 1));
		// Repeated square cancels out; empty last square with no extras
		pending_squares.push_back(board_square(10, 1, 2, 0, 0));
		pending_squares.push_back(board_square(10, 1, 2, 0, 0));
		pending_squares.push_back(board_square(33, 1, 6, 1, 1));
		pending_squares.push_back(closing(board_square(0, 0, 0, 0, 0), 0, 0, 7, 0));
		// Back-to-back single-square positions, last square hashed itself
		pending_squares.push_back(closing(board_square(63, 1, 15, 1, 0), 10, 1, 0, 0));
		pending_squares.push_back(closing(board_square(21, 0, 9, 1, 0), 5, 1, 3, 1));
		pending_squares.push_back(closing(board_square(62, 1, 0, 1, 0), 1, 0, 0, 1));
		queue_positions(180);
		drain_all();

		send_idle_pct = 87;
		recv_idle_pct = 11;
		queue_positions(180);
		drain_all();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_positions(190);
		drain_all();
		repeat (60) @(negedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#8000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
